@@ rtl/tlb_lru_lookup_fill_flush_top_defines.svh @@
// Assertion macros for the port-level checker of the translation buffer.
`ifndef TLB_LRU_LOOKUP_FILL_FLUSH_TOP_DEFINES_SVH
`define TLB_LRU_LOOKUP_FILL_FLUSH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted while arst_n is low.
`define TLBL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlbl check failed");

// Next-cycle implication, sampled on clk and muted while arst_n is low.
`define TLBL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlbl check failed");

`endif

@@ rtl/tlbl_pkg.sv @@
// Shared constants, request codes and control types of the translation buffer.
package tlbl_pkg;

	localparam int ENTRIES = 4;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int PAGE_W  = 10;
	localparam int OFF_W   = 12;
	localparam int FRAME_W = 8;
	localparam int PA_W    = FRAME_W + OFF_W;
	localparam int REQ_W   = 2;

	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FILL   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [OCC_W-1:0]   occ_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the request beat
		logic compare;  // register the tag match and LRU search
		logic update;   // commit the entry update and the result
	} cmd_t;

endpackage

@@ rtl/tlbl_ctrl.sv @@
// Controller state machine: request handshake, step sequencing, result handshake.
module tlbl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output tlbl_pkg::cmd_t cmd
);
	import tlbl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_n     = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_n    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ rtl/tlbl_dp.sv @@
// Datapath: entry registers, tag compare, LRU ranks and the result register.
module tlbl_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlbl_pkg::cmd_t              cmd,
	input  logic [tlbl_pkg::REQ_W-1:0]  req_type,
	input  tlbl_pkg::page_t             virt_page,
	input  logic [tlbl_pkg::OFF_W-1:0]  page_offset,
	input  tlbl_pkg::frame_t            fill_frame,
	output logic                        hit,
	output tlbl_pkg::frame_t            frame_out,
	output logic [tlbl_pkg::PA_W-1:0]   physical_address,
	output logic                        evicted_valid,
	output tlbl_pkg::page_t             evicted_page,
	output logic                        flushed,
	output tlbl_pkg::occ_t              occupancy
);
	import tlbl_pkg::*;

	// Captured request.
	logic [REQ_W-1:0] req_q;
	page_t            page_q;
	logic [OFF_W-1:0] off_q;
	frame_t           fill_q;

	// Entry store; valid entries always sit in slots below cnt_q.
	page_t  pg_q [ENTRIES];
	frame_t fr_q [ENTRIES];
	idx_t   rk_q [ENTRIES];
	occ_t   cnt_q;

	// Compare step results.
	logic hit_s1;
	idx_t slot_s1;
	idx_t lru_s1;

	logic hit_c;
	idx_t slot_c;
	idx_t lru_c;
	logic lru_found;

	// Next state and result of the update step.
	page_t  pg_n [ENTRIES];
	frame_t fr_n [ENTRIES];
	idx_t   rk_n [ENTRIES];
	occ_t   cnt_n;
	logic   r_hit;
	frame_t r_frame;
	logic   r_ev;
	page_t  r_evp;
	logic   r_fl;
	logic   do_touch;
	idx_t   tgt;
	idx_t   old_rk;
	idx_t   src_rk;
	idx_t   gone_rk;
	int     sidx;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			page_q <= virt_page;
			off_q  <= page_offset;
			fill_q <= fill_frame;
		end
	end

	// Lowest matching valid slot, and lowest slot holding the oldest rank.
	always_comb begin
		hit_c     = 1'b0;
		slot_c    = '0;
		lru_found = 1'b0;
		lru_c     = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!hit_c && (OCC_W'(i) < cnt_q) && (pg_q[i] == page_q)) begin
				hit_c  = 1'b1;
				slot_c = IDX_W'(i);
			end
			if (!lru_found && (rk_q[i] == '0)) begin
				lru_found = 1'b1;
				lru_c     = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			hit_s1  <= hit_c;
			slot_s1 <= slot_c;
			lru_s1  <= lru_c;
		end
	end

	always_comb begin
		pg_n     = pg_q;
		fr_n     = fr_q;
		rk_n     = rk_q;
		cnt_n    = cnt_q;
		r_hit    = 1'b0;
		r_frame  = '0;
		r_ev     = 1'b0;
		r_evp    = '0;
		r_fl     = 1'b0;
		do_touch = 1'b0;
		tgt      = slot_s1;
		old_rk   = '0;
		src_rk   = '0;
		gone_rk  = rk_q[slot_s1];
		sidx     = 0;
		case (req_q)
			REQ_LOOKUP: begin
				if (hit_s1) begin
					r_hit    = 1'b1;
					r_frame  = fr_q[slot_s1];
					do_touch = 1'b1;
				end
			end
			REQ_FILL: begin
				r_frame = fill_q;
				if (hit_s1) begin
					fr_n[slot_s1] = fill_q;
					do_touch      = 1'b1;
				end else if (cnt_q < OCC_W'(ENTRIES)) begin
					pg_n[cnt_q[IDX_W-1:0]] = page_q;
					fr_n[cnt_q[IDX_W-1:0]] = fill_q;
					rk_n[cnt_q[IDX_W-1:0]] = cnt_q[IDX_W-1:0];
					cnt_n                  = cnt_q + OCC_W'(1);
				end else begin
					r_ev         = 1'b1;
					r_evp        = pg_q[lru_s1];
					pg_n[lru_s1] = page_q;
					fr_n[lru_s1] = fill_q;
					tgt          = lru_s1;
					do_touch     = 1'b1;
				end
			end
			REQ_FLUSH: begin
				if (hit_s1) begin
					r_fl  = 1'b1;
					cnt_n = cnt_q - OCC_W'(1);
					// Entries above the removed slot move down one place; ranks
					// above the removed rank close the gap.
					for (int i = 0; i < ENTRIES; i++) begin
						sidx = i;
						if ((i < ENTRIES - 1) && (IDX_W'(i) >= slot_s1)) begin
							sidx = i + 1;
						end
						pg_n[i] = pg_q[sidx];
						fr_n[i] = fr_q[sidx];
						src_rk  = rk_q[sidx];
						rk_n[i] = (src_rk > gone_rk) ? src_rk - IDX_W'(1) : src_rk;
					end
				end
			end
			default: begin
			end
		endcase
		if (do_touch) begin
			old_rk = rk_q[tgt];
			for (int i = 0; i < ENTRIES; i++) begin
				if ((OCC_W'(i) < cnt_q) && (rk_q[i] > old_rk)) begin
					rk_n[i] = rk_q[i] - IDX_W'(1);
				end
			end
			rk_n[tgt] = IDX_W'(cnt_q - OCC_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			pg_q             <= pg_n;
			fr_q             <= fr_n;
			rk_q             <= rk_n;
			hit              <= r_hit;
			frame_out        <= r_frame;
			physical_address <= r_hit ? {r_frame, off_q} : '0;
			evicted_valid    <= r_ev;
			evicted_page     <= r_evp;
			flushed          <= r_fl;
			occupancy        <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			cnt_q <= cnt_n;
		end
	end

endmodule

@@ rtl/tlb_lru_lookup_fill_flush_top.sv @@
// Top level of the fully associative translation buffer with LRU replacement.
// The buffer holds four entries in flip-flops and serves one request at a time:
// a beat is taken when in_valid and in_ready are high, the tag compare runs in
// the next cycle, the entry and rank update with the result register in the
// cycle after that, and the result beat is then offered on out_valid until it
// is taken; a request passes through the capture, compare, update and result
// steps of the controller. Lookups return the frame and the physical address
// on a hit, fills overwrite a matching entry, install a new one or evict the
// least recently used entry, flushes remove a hit entry and compact the store.
// Every request, including the unused code, produces exactly one result beat.
module tlb_lru_lookup_fill_flush_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tlbl_pkg::REQ_W-1:0]  req_type,
	input  tlbl_pkg::page_t             virt_page,
	input  logic [tlbl_pkg::OFF_W-1:0]  page_offset,
	input  tlbl_pkg::frame_t            fill_frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output tlbl_pkg::frame_t            frame_out,
	output logic [tlbl_pkg::PA_W-1:0]   physical_address,
	output logic                        evicted_valid,
	output tlbl_pkg::page_t             evicted_page,
	output logic                        flushed,
	output tlbl_pkg::occ_t              occupancy
);
	import tlbl_pkg::*;

	cmd_t cmd;

	tlbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tlbl_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.req_type         (req_type),
		.virt_page        (virt_page),
		.page_offset      (page_offset),
		.fill_frame       (fill_frame),
		.hit              (hit),
		.frame_out        (frame_out),
		.physical_address (physical_address),
		.evicted_valid    (evicted_valid),
		.evicted_page     (evicted_page),
		.flushed          (flushed),
		.occupancy        (occupancy)
	);

endmodule

@@ rtl/tlbl_chk.sv @@
// Port-level checker of the translation buffer and its bind to the top level.
`include "tlb_lru_lookup_fill_flush_top_defines.svh"

module tlbl_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        hit,
	input tlbl_pkg::frame_t            frame_out,
	input logic [tlbl_pkg::PA_W-1:0]   physical_address,
	input logic                        evicted_valid,
	input tlbl_pkg::page_t             evicted_page,
	input logic                        flushed,
	input tlbl_pkg::occ_t              occupancy
);
	import tlbl_pkg::*;

	// A waiting result beat holds its physical address and occupancy.
	`TLBL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(physical_address) && $stable(occupancy))

	// Only one request is in flight: after a beat is taken no other is taken
	// until its result has left.
	`TLBL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// A result never reports more entries than the buffer holds.
	`TLBL_ASSERT_NOW(a_occ_range, out_valid, occupancy <= OCC_W'(ENTRIES))

	// An eviction only happens from a full buffer, and never with a hit or flush.
	`TLBL_ASSERT_NOW(a_evict_full, out_valid && evicted_valid, occupancy == OCC_W'(ENTRIES) && !hit && !flushed)

	// A hit result carries its frame in the upper bits of the physical address.
	`TLBL_ASSERT_NOW(a_hit_addr, out_valid && hit, physical_address[PA_W-1:OFF_W] == frame_out)

endmodule

bind tlb_lru_lookup_fill_flush_top tlbl_chk u_tlbl_chk (.*);
